// ----- rtl/r2h_pkg.sv -----
// ----------------------------------------------------------------------------
// r2h_pkg: shared types and helpers of the RGB to HSV converter
// Sector codes, the per-pixel sector record and the restoring division step
// used by the quotient stages.
// ----------------------------------------------------------------------------
package r2h_pkg;

   localparam int unsigned COMP_W     = 8;
   localparam int unsigned HUE_W      = 11;
   localparam int unsigned HUE_FRAC_W = 8;
   localparam int unsigned BASE_W     = 3;

   // Base sector picked by the channel that holds the minimum
   localparam logic [BASE_W-1:0] BASE_RED_MIN   = 3'd3;
   localparam logic [BASE_W-1:0] BASE_GREEN_MIN = 3'd5;
   localparam logic [BASE_W-1:0] BASE_BLUE_MIN  = 3'd1;

   // Most quotient bits resolved in any one divider stage
   localparam int unsigned MAX_STEPS = 4;

   typedef struct packed {
      logic [COMP_W-1:0]   v;
      logic [COMP_W-1:0]   d;
      logic signed [COMP_W:0] f;
      logic [BASE_W-1:0]   base;
      logic                undef;
   } sector_type;

   typedef struct packed {
      logic [COMP_W-1:0] hue_rem;
      logic [HUE_W-1:0]  hue_num;
      logic [HUE_W-1:0]  hue_q;
      logic [COMP_W-1:0] sat_rem;
      logic [COMP_W-1:0] sat_num;
      logic [COMP_W-1:0] sat_q;
      logic [COMP_W-1:0] d;
      logic [COMP_W-1:0] v;
      logic              undef;
   } div_state_type;

   // One restoring step: shift in the next numerator bit, subtract if it fits
   function automatic logic [COMP_W:0] div_step(
      input logic [COMP_W-1:0] rem,
      input logic              nbit,
      input logic [COMP_W-1:0] dvs
   );
      logic [COMP_W:0] t;
      logic [COMP_W:0] diff;
      t    = {rem, nbit};
      diff = t - {1'b0, dvs};
      if (t >= {1'b0, dvs}) begin
         div_step = {1'b1, diff[COMP_W-1:0]};
      end else begin
         div_step = {1'b0, t[COMP_W-1:0]};
      end
   endfunction

   // Advance both divisions by a few quotient bits
   function automatic div_state_type div_advance(
      input div_state_type s,
      input int unsigned   hue_steps,
      input int unsigned   sat_steps
   );
      div_state_type   r;
      logic [COMP_W:0] res;
      r = s;
      for (int unsigned i = 0; i < MAX_STEPS; i++) begin
         if (i < hue_steps) begin
            res       = div_step(r.hue_rem, r.hue_num[HUE_W-1], r.d);
            r.hue_rem = res[COMP_W-1:0];
            r.hue_q   = {r.hue_q[HUE_W-2:0], res[COMP_W]};
            r.hue_num = {r.hue_num[HUE_W-2:0], 1'b0};
         end
         if (i < sat_steps) begin
            res       = div_step(r.sat_rem, r.sat_num[COMP_W-1], r.v);
            r.sat_rem = res[COMP_W-1:0];
            r.sat_q   = {r.sat_q[COMP_W-2:0], res[COMP_W]};
            r.sat_num = {r.sat_num[COMP_W-2:0], 1'b0};
         end
      end
      div_advance = r;
   endfunction

endpackage

// ----- rtl/r2h_sector.sv -----
// ----------------------------------------------------------------------------
// r2h_sector: extremes and hexcone sector of one pixel
// Finds max and min, their spread, the base sector and the signed
// difference term; flags a grey pixel.
// ----------------------------------------------------------------------------
module r2h_sector import r2h_pkg::*; (
   input  logic [COMP_W-1:0] red,
   input  logic [COMP_W-1:0] green,
   input  logic [COMP_W-1:0] blue,
   output sector_type        sector
);

   logic [COMP_W-1:0] mx_rg;
   logic [COMP_W-1:0] mn_rg;
   logic [COMP_W-1:0] v;
   logic [COMP_W-1:0] x;

   assign mx_rg = (red > green) ? red : green;
   assign mn_rg = (red < green) ? red : green;
   assign v     = (mx_rg > blue) ? mx_rg : blue;
   assign x     = (mn_rg < blue) ? mn_rg : blue;

   always_comb begin
      sector.v     = v;
      sector.d     = v - x;
      sector.undef = (v == x);
      // first channel in red, green, blue order holding the minimum wins
      priority if (red == x) begin
         sector.base = BASE_RED_MIN;
         sector.f    = $signed({1'b0, green}) - $signed({1'b0, blue});
      end else if (green == x) begin
         sector.base = BASE_GREEN_MIN;
         sector.f    = $signed({1'b0, blue}) - $signed({1'b0, red});
      end else begin
         sector.base = BASE_BLUE_MIN;
         sector.f    = $signed({1'b0, red}) - $signed({1'b0, green});
      end
   end

endmodule

// ----- rtl/rgb_to_hsv_converter.sv -----
// One pixel per clock unless rsp_tready holds the output back. The
// pipeline has an input register, a sector stage (max, min, base sector), and
// three restoring-division stages that resolve hue (4+4+3 bits) and
// saturation (3+3+2 bits) in parallel; the last of them is the output
// register. Each stage stalls only when it holds data and the stage after it
// cannot take it, so bubbles collapse under back pressure. Hue is in sixths
// of a circle with 8 fraction bits (0..1536), truncated; a grey pixel raises
// hue_undefined on rsp_tuser with all tdata fields zero.
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter: streaming RGB to HSV hexcone converter
// Five-stage pipeline with per-stage valid bits and stall propagation.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter import r2h_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red [7:0], green [15:8], blue [23:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // hue [10:0], saturation [18:11],
                                    // brightness [26:19], zero [31:27]
   output logic        rsp_tuser    // hue_undefined [0]
);

   localparam int unsigned NSTAGE = 5;

   logic [NSTAGE-1:0] valid_ff;
   logic [NSTAGE-1:0] valid_in;
   logic [NSTAGE-1:0] adv;

   logic [3*COMP_W-1:0] pix_ff;
   sector_type          sector;
   sector_type          sec_ff;
   div_state_type       div_start;
   div_state_type       dv1_ff, dv1_in;
   div_state_type       dv2_ff, dv2_in;
   div_state_type       dv3_ff, dv3_in;

   logic [HUE_W-1:0]      base_d;
   logic [HUE_W-1:0]      hue_num;
   logic [2*COMP_W-1:0]   sat_num;

   // stall propagation: a stage moves when empty or when its successor moves
   always_comb begin
      adv[NSTAGE-1] = !valid_ff[NSTAGE-1] || rsp_tready;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
      valid_in[0] = req_tvalid;
      for (int k = 1; k < NSTAGE; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   assign req_tready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NSTAGE; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   r2h_sector u_sector (
      .red    (pix_ff[COMP_W-1:0]),
      .green  (pix_ff[2*COMP_W-1:COMP_W]),
      .blue   (pix_ff[3*COMP_W-1:2*COMP_W]),
      .sector (sector)
   );

   // numerators: (base*d - f) << 8 for hue, d*255 for saturation
   always_comb begin
      base_d  = HUE_W'(sec_ff.d) * HUE_W'(sec_ff.base);
      // base*d - f stays within 0..6*d, so 11 bits hold it
      hue_num = base_d - HUE_W'(sec_ff.f);
      sat_num = {sec_ff.d, {COMP_W{1'b0}}} - (2 * COMP_W)'(sec_ff.d);

      // quotient of hue is below 2^11, so the top numerator bits start
      // as remainder already below the divisor
      div_start.hue_rem = hue_num[HUE_W-1:HUE_W-COMP_W];
      div_start.hue_num = {hue_num[HUE_W-COMP_W-1:0], {HUE_FRAC_W{1'b0}}};
      div_start.hue_q   = '0;
      div_start.sat_rem = sat_num[2*COMP_W-1:COMP_W];
      div_start.sat_num = sat_num[COMP_W-1:0];
      div_start.sat_q   = '0;
      div_start.d       = sec_ff.d;
      div_start.v       = sec_ff.v;
      div_start.undef   = sec_ff.undef;

      dv1_in = div_advance(div_start, 4, 3);
      dv2_in = div_advance(dv1_ff, 4, 3);
      dv3_in = div_advance(dv2_ff, 3, 2);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         pix_ff <= req_tdata;
      end
      if (adv[1]) begin
         sec_ff <= sector;
      end
      if (adv[2]) begin
         dv1_ff <= dv1_in;
      end
      if (adv[3]) begin
         dv2_ff <= dv2_in;
      end
      if (adv[4]) begin
         dv3_ff <= dv3_in;
      end
   end

   // zero all tdata fields on a grey pixel
   assign rsp_tvalid = valid_ff[NSTAGE-1];
   assign rsp_tuser  = dv3_ff.undef;
   assign rsp_tdata  = dv3_ff.undef ? '0 :
                       {5'b0, dv3_ff.v, dv3_ff.sat_q, dv3_ff.hue_q};

   a_grey_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("grey pixel result carries nonzero fields");

   a_hue_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[10:0] <= 11'd1536)
      else $error("hue beyond full turn");

   a_bright_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[26:19] != 8'd0)
      else $error("colored pixel with zero brightness");

   a_accept_moves : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> valid_ff[0])
      else $error("accepted transaction not captured");

endmodule

// ----- verif/rgb_to_hsv_converter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_tb: self-checking bench for the RGB to HSV converter
// Streams pixels into the converter with random gaps and random back pressure.
// Each accepted pixel is run through a behavioral hexcone model, and every
// response is compared field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_tb import r2h_pkg::*;;

   localparam int unsigned RESET_CYCLES = 6;
   localparam int unsigned DRAIN_CYCLES = 12;
   localparam time         RUN_LIMIT    = 2_000_000ns;

   typedef struct packed {
      logic [HUE_W-1:0]  hue;
      logic [COMP_W-1:0] saturation;
      logic [COMP_W-1:0] brightness;
      logic              hue_undefined;
   } hsv_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;      // red [7:0], green [15:8], blue [23:16]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;           // hue [10:0], saturation [18:11],
                                     // brightness [26:19], zero [31:27]
   logic        rsp_tuser;           // hue_undefined [0]

   hsv_result_type expected_hsv[$];
   int unsigned pixels_sent     = 0;
   int unsigned grey_sent       = 0;
   int unsigned full_turn_sent  = 0;
   int unsigned results_checked = 0;
   int unsigned mismatch_count  = 0;
   bit          no_idle         = 1'b0;
   int unsigned stall_left      = 0;

   rgb_to_hsv_converter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   // Hexcone conversion with integer arithmetic; truncating divisions
   function automatic hsv_result_type predict_hsv(input logic [7:0] r, g, b);
      hsv_result_type res;
      int          red, green, blue, v, x, d, f, base_sector;
      red   = r;
      green = g;
      blue  = b;
      v     = (red > green) ? red : green;
      v     = (v > blue) ? v : blue;
      x     = (red < green) ? red : green;
      x     = (x < blue) ? x : blue;
      res   = '0;
      if (v == x) begin
         res.hue_undefined = 1'b1;
         return res;
      end
      d = v - x;
      // earliest channel wins a tie for the minimum
      if (red == x) begin
         base_sector = BASE_RED_MIN;
         f = green - blue;
      end else if (green == x) begin
         base_sector = BASE_GREEN_MIN;
         f = blue - red;
      end else begin
         base_sector = BASE_BLUE_MIN;
         f = red - green;
      end
      res.hue        = HUE_W'(((base_sector * d - f) * (1 << HUE_FRAC_W)) / d);
      res.saturation = COMP_W'((d * 255) / v);
      res.brightness = COMP_W'(v);
      return res;
   endfunction

   // Mostly back-to-back, some short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (no_idle) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_pixel(input logic [7:0] r, g, b);
      int unsigned gap;
      hsv_result_type want;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 24'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {b, g, r};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      want = predict_hsv(r, g, b);
      expected_hsv.push_back(want);
      pixels_sent++;
      if (want.hue_undefined) grey_sent++;
      if (want.hue == HUE_W'(6 << HUE_FRAC_W)) full_turn_sent++;
   endtask

   // Hold the sender idle until every pending response has been checked
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_hsv.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_pixel();
      logic [7:0] comp[3];
      int unsigned kind;
      kind = $urandom_range(0, 9);
      foreach (comp[i]) comp[i] = 8'($urandom);
      case (kind)
         0: begin
            comp[1] = comp[0];
            comp[2] = comp[0];
         end
         1: begin
            comp[$urandom_range(0, 2)] = comp[$urandom_range(0, 2)];
         end
         2: begin
            foreach (comp[i]) begin
               case ($urandom_range(0, 2))
                  0: comp[i] = 8'd0;
                  1: comp[i] = 8'd255;
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
      send_pixel(comp[0], comp[1], comp[2]);
   endtask

   task automatic test_directed_pixels();
      send_pixel(8'd0,   8'd0,   8'd0);     // black
      send_pixel(8'd255, 8'd255, 8'd255);   // white
      send_pixel(8'd128, 8'd128, 8'd128);   // mid grey
      send_pixel(8'd255, 8'd0,   8'd0);     // pure red: full turn
      send_pixel(8'd0,   8'd255, 8'd0);
      send_pixel(8'd0,   8'd0,   8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0,   8'd255, 8'd255);
      send_pixel(8'd255, 8'd0,   8'd255);
      send_pixel(8'd1,   8'd0,   8'd0);     // smallest spread, full turn
      send_pixel(8'd255, 8'd254, 8'd254);
      send_pixel(8'd10,  8'd10,  8'd200);   // red and green tie for minimum
      send_pixel(8'd200, 8'd10,  8'd10);    // green and blue tie
      send_pixel(8'd10,  8'd200, 8'd10);    // red and blue tie
      send_pixel(8'd0,   8'd1,   8'd255);
      send_pixel(8'd128, 8'd0,   8'd1);
      send_pixel(8'd200, 8'd100, 8'd50);
      send_pixel(8'd1,   8'd2,   8'd3);
      send_pixel(8'd254, 8'd255, 8'd0);
      send_pixel(8'd85,  8'd170, 8'd255);
      wait_drain();
   endtask

   task automatic test_random_pixels(input int unsigned count);
      repeat (count) send_random_pixel();
      wait_drain();
   endtask

   // Send bursts, then pause the sender until the pipeline is empty
   task automatic test_drain_between_bursts();
      repeat (4) begin
         repeat ($urandom_range(20, 60)) send_random_pixel();
         wait_drain();
      end
   endtask

   task automatic test_back_to_back();
      no_idle = 1'b1;
      repeat (150) send_random_pixel();
      no_idle = 1'b0;
      wait_drain();
   endtask

   always @(posedge clock) begin : rsp_check
      hsv_result_type want;
      hsv_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.hue           = rsp_tdata[10:0];
         got.saturation    = rsp_tdata[18:11];
         got.brightness    = rsp_tdata[26:19];
         got.hue_undefined = rsp_tuser;
         if (expected_hsv.size() == 0) begin
            $display("%0t: unexpected transaction: hue %0d sat %0d bri %0d undef %0b",
                     $time, got.hue, got.saturation, got.brightness, got.hue_undefined);
            mismatch_count++;
         end else begin
            want = expected_hsv.pop_front();
            results_checked++;
            if (got.hue !== want.hue) begin
               $display("%0t: hue: expected %0d, actual %0d", $time, want.hue, got.hue);
               mismatch_count++;
            end
            if (got.saturation !== want.saturation) begin
               $display("%0t: saturation: expected %0d, actual %0d",
                        $time, want.saturation, got.saturation);
               mismatch_count++;
            end
            if (got.brightness !== want.brightness) begin
               $display("%0t: brightness: expected %0d, actual %0d",
                        $time, want.brightness, got.brightness);
               mismatch_count++;
            end
            if (got.hue_undefined !== want.hue_undefined) begin
               $display("%0t: hue_undefined: expected %0b, actual %0b",
                        $time, want.hue_undefined, got.hue_undefined);
               mismatch_count++;
            end
         end
      end
      // back pressure: mostly ready, short stalls, occasional long ones
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (no_idle) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= 1'b1;
         case ($urandom_range(0, 19))
            0, 1, 2, 3: stall_left = $urandom_range(1, 3);
            4:          stall_left = $urandom_range(8, 40);
            default:    ;
         endcase
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_pixels();
      test_random_pixels(1300);
      test_drain_between_bursts();
      test_back_to_back();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d pixels (%0d grey, %0d at full turn); checked %0d responses",
               pixels_sent, grey_sent, full_turn_sent, results_checked);
      $display("Traffic mixed random gaps, back pressure and unthrottled stretches");
      if (mismatch_count == 0 && expected_hsv.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #RUN_LIMIT;
      $display("%0t: timeout with %0d responses pending", $time, expected_hsv.size());
      $display("FAILED: results differ");
      $finish;
   end

endmodule
